// File: hw/rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg: shared definitions for the per-MAC request rate limiter
// Table geometry, field widths, protocol constants, register indexes and the
// record types passed between the limiter's modules.
// ----------------------------------------------------------------------------
package prl_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int USE_W = 7;
  localparam int SZ_W = (CNT_W > USE_W) ? CNT_W : USE_W;
  localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(TABLE_ENTRIES - 1);

  // Field widths.
  localparam int HTYPE_W = 8;
  localparam int ALEN_W = 5;
  localparam int MAC_W = 48;
  localparam int TIME_W = 32;
  localparam int COUNT_W = 16;
  localparam int LIMIT_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 8'd1;

  // Protocol constants.
  localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = 16'd100;
  localparam logic [USE_W-1:0] ENTRIES_RESET = 7'd64;
  localparam logic [HTYPE_W-1:0] ETHER_TYPE = 8'd1;
  localparam logic [ALEN_W-1:0] ETHER_ADDR_LEN = 5'd6;
  localparam logic [TIME_W-1:0] WINDOW_MS = 32'd2000;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0] win_start;
  } entry_t;

  // Effective configuration after range fixes.
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [CNT_W-1:0] size;
  } cfg_t;

endpackage

// File: hw/rtl/prl_ram.sv
// ----------------------------------------------------------------------------
// prl_ram: generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module prl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/prl_cfg.sv
// ----------------------------------------------------------------------------
// prl_cfg: configuration registers
// Holds the request limit and the table size, and presents them with the
// zero limit and out-of-range sizes already mapped to usable values.
// ----------------------------------------------------------------------------
module prl_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [prl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prl_pkg::CFG_DATA_W-1:0] cfg_data,
  output prl_pkg::cfg_t                  cfg
);
  import prl_pkg::*;

  logic [LIMIT_W-1:0] max_requests;
  logic [USE_W-1:0] entries_in_use;
  logic [SZ_W-1:0] size_req;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_requests <= DEFAULT_LIMIT;
      entries_in_use <= ENTRIES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_REQUESTS: max_requests <= cfg_data[LIMIT_W-1:0];
        REG_ENTRIES_IN_USE: entries_in_use <= cfg_data[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero limit acts as the default; the size is clamped to the table.
  always_comb begin
    size_req = SZ_W'(entries_in_use);
    cfg.limit = (max_requests == '0) ? DEFAULT_LIMIT : max_requests;
    if (size_req == '0) begin
      cfg.size = CNT_W'(1);
    end else if (size_req > SZ_W'(TABLE_ENTRIES)) begin
      cfg.size = CNT_W'(TABLE_ENTRIES);
    end else begin
      cfg.size = size_req[CNT_W-1:0];
    end
  end

endmodule

// File: hw/rtl/per_mac_request_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// per_mac_request_rate_limiter_top: per-MAC request rate limiter with LRU table
// Non-Ethernet and bad-length requests skip the table. Table lookups make two
// sweeps over the active entries of the table memories at one entry per cycle:
// a search pass and an aging pass. Throughput: one request at a time; the next
// is taken only once the last verdict has entered the output register, which
// waits while an earlier verdict is held there. Reset clears all valid bits at once.
// ----------------------------------------------------------------------------
module per_mac_request_rate_limiter_top (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prl_pkg::CFG_DATA_W-1:0] cfg_data,
  // Requests.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [prl_pkg::HTYPE_W-1:0]    hardware_type,
  input  logic [prl_pkg::ALEN_W-1:0]     address_length,
  input  logic [prl_pkg::MAC_W-1:0]      mac_address,
  input  logic [prl_pkg::TIME_W-1:0]     time_ms,
  // Verdicts.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           allowed
);
  import prl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_AGE,
    S_FINISH
  } state_t;

  state_t state;
  cfg_t cfg;

  // Request being processed.
  logic [MAC_W-1:0] mac_q;
  logic [TIME_W-1:0] time_q;
  logic res;

  // Sweep pipeline: read issue counter and the entry whose data is returning.
  logic [CNT_W-1:0] rd_idx;
  logic p_vld;
  logic [IDX_W-1:0] p_idx;

  // Search results.
  logic hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_age;
  logic [COUNT_W-1:0] hit_count;
  logic [TIME_W-1:0] hit_win;
  logic free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] max_idx;
  logic [IDX_W-1:0] max_age;

  // Aging pass parameters.
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] limit_age;
  logic age_all;

  logic [TABLE_ENTRIES-1:0] valid_bits;

  // Memory ports.
  logic ent_we;
  entry_t ent_wdata;
  logic [$bits(entry_t)-1:0] ent_rd_raw;
  entry_t ent_rd;
  logic [IDX_W-1:0] rd_addr;
  logic age_we;
  logic [IDX_W-1:0] age_wdata;
  logic [IDX_W-1:0] age_rd;

  // Decision logic.
  logic [TIME_W-1:0] elapsed;
  logic [COUNT_W:0] cnt_inc;
  logic [IDX_W-1:0] dec_slot;
  logic [IDX_W-1:0] dec_limit;
  logic dec_all;
  logic dec_write;
  logic dec_allow;
  logic [COUNT_W-1:0] dec_count;
  logic [TIME_W-1:0] dec_win;

  // Aging logic.
  logic [IDX_W-1:0] age_inc;
  logic age_wr;

  logic sweep_done;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);

  prl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Entry memory: MAC, count and window start per slot.
  prl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (dec_slot),
    .wdata (ent_wdata),
    .raddr (rd_addr),
    .rdata (ent_rd_raw)
  );

  // Age memory: LRU rank per slot, zero is most recent.
  prl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (p_idx),
    .wdata (age_wdata),
    .raddr (rd_addr),
    .rdata (age_rd)
  );

  assign ent_rd = entry_t'(ent_rd_raw);
  assign rd_addr = rd_idx[IDX_W-1:0];
  assign sweep_done = (rd_idx >= cfg.size) && !p_vld;

  // Verdict and entry update from the search results.
  always_comb begin
    elapsed = time_q - hit_win;
    cnt_inc = {1'b0, hit_count} + (COUNT_W + 1)'(1);
    dec_write = 1'b1;
    dec_allow = 1'b1;
    dec_count = COUNT_W'(1);
    dec_win = time_q;
    if (hit) begin
      dec_slot = hit_idx;
      dec_limit = hit_age;
      dec_all = 1'b0;
      if (elapsed >= WINDOW_MS) begin
        dec_count = COUNT_W'(1);
      end else if (cnt_inc < {1'b0, cfg.limit}) begin
        dec_count = cnt_inc[COUNT_W-1:0];
        dec_win = hit_win;
      end else begin
        dec_write = 1'b0;
        dec_allow = 1'b0;
        dec_count = hit_count;
        dec_win = hit_win;
      end
    end else if (free_found) begin
      dec_slot = free_idx;
      dec_limit = '0;
      dec_all = 1'b1;
    end else begin
      dec_slot = max_idx;
      dec_limit = max_age;
      dec_all = 1'b0;
    end
    ent_we = (state == S_DECIDE) && dec_write;
    ent_wdata.mac = mac_q;
    ent_wdata.count = dec_count;
    ent_wdata.win_start = dec_win;
  end

  // Age update for the entry returning from the age memory.
  always_comb begin
    age_inc = (age_rd < AGE_MAX) ? age_rd + IDX_W'(1) : age_rd;
    if (p_idx == slot) begin
      age_wr = 1'b1;
      age_wdata = '0;
    end else if (valid_bits[p_idx] && (age_all || age_rd < limit_age)) begin
      age_wr = 1'b1;
      age_wdata = age_inc;
    end else begin
      age_wr = 1'b0;
      age_wdata = age_rd;
    end
    age_we = (state == S_AGE) && p_vld && age_wr;
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      p_vld <= 1'b0;
      valid_bits <= '0;
    end else begin
      // A verdict leaving without a new one behind it empties the output.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mac_q <= mac_address;
            time_q <= time_ms;
            rd_idx <= '0;
            p_vld <= 1'b0;
            hit <= 1'b0;
            free_found <= 1'b0;
            if (hardware_type != ETHER_TYPE) begin
              res <= 1'b1;
              state <= S_FINISH;
            end else if (address_length != ETHER_ADDR_LEN) begin
              res <= 1'b0;
              state <= S_FINISH;
            end else begin
              state <= S_SEARCH;
            end
          end
        end

        // Sweep all active entries: first match, first free slot, oldest slot.
        S_SEARCH: begin
          if (rd_idx < cfg.size) begin
            p_vld <= 1'b1;
            p_idx <= rd_idx[IDX_W-1:0];
            rd_idx <= rd_idx + CNT_W'(1);
          end else begin
            p_vld <= 1'b0;
          end
          if (p_vld) begin
            if (valid_bits[p_idx] && ent_rd.mac == mac_q && !hit) begin
              hit <= 1'b1;
              hit_idx <= p_idx;
              hit_age <= age_rd;
              hit_count <= ent_rd.count;
              hit_win <= ent_rd.win_start;
            end
            if (!valid_bits[p_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= p_idx;
            end
            if (p_idx == '0 || age_rd > max_age) begin
              max_idx <= p_idx;
              max_age <= age_rd;
            end
          end
          if (sweep_done) begin
            state <= S_DECIDE;
          end
        end

        // Entry memory is written this cycle; set up the aging pass.
        S_DECIDE: begin
          slot <= dec_slot;
          limit_age <= dec_limit;
          age_all <= dec_all;
          res <= dec_allow;
          valid_bits[dec_slot] <= 1'b1;
          rd_idx <= '0;
          p_vld <= 1'b0;
          state <= S_AGE;
        end

        // Read-modify-write of each age; the write trails the read by one entry.
        S_AGE: begin
          if (rd_idx < cfg.size) begin
            p_vld <= 1'b1;
            p_idx <= rd_idx[IDX_W-1:0];
            rd_idx <= rd_idx + CNT_W'(1);
          end else begin
            p_vld <= 1'b0;
          end
          if (sweep_done) begin
            state <= S_FINISH;
          end
        end

        // Hand the verdict to the output register once it is free.
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            allowed <= res;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/per_mac_request_rate_limiter_top_tb.sv
// ----------------------------------------------------------------------------
// per_mac_request_rate_limiter_top_tb: self-checking bench for the rate limiter
// Drives DHCP-style requests and register writes into the limiter. A scoreboard
// keeps its own copy of the LRU table and predicts every verdict. Each verdict
// that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module per_mac_request_rate_limiter_top_tb;
  import prl_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 12;
  localparam int POOL_SIZE = 80;

  // Predicts each verdict from a private copy of the table and the registers.
  class verdict_scoreboard;
    bit                 slot_used   [TABLE_ENTRIES];
    bit [MAC_W-1:0]     slot_mac    [TABLE_ENTRIES];
    bit [COUNT_W-1:0]   slot_hits   [TABLE_ENTRIES];
    bit [TIME_W-1:0]    slot_window [TABLE_ENTRIES];
    bit [IDX_W-1:0]     slot_rank   [TABLE_ENTRIES];
    bit [LIMIT_W-1:0]   limit_reg;
    bit [USE_W-1:0]     size_reg;
    bit                 verdicts_due [$];
    int                 checked;
    int                 granted;
    int                 mismatches;

    function void clear();
      limit_reg = DEFAULT_LIMIT;
      size_reg = ENTRIES_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_mac[i] = '0;
        slot_hits[i] = '0;
        slot_window[i] = '0;
        slot_rank[i] = '0;
      end
      verdicts_due.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      // Writes to unknown indexes are dropped.
      if (idx == REG_MAX_REQUESTS) begin
        limit_reg = data[LIMIT_W-1:0];
      end else if (idx == REG_ENTRIES_IN_USE) begin
        size_reg = data[USE_W-1:0];
      end
    endfunction

    function int active_slots();
      int n = size_reg;
      if (n == 0) n = 1;
      if (n > TABLE_ENTRIES) n = TABLE_ENTRIES;
      return n;
    endfunction

    // Make slot s the most recent one; older ranks saturate at the top.
    function void promote(int s, bit [IDX_W-1:0] rank_cap, bit age_all, int n);
      for (int i = 0; i < n; i++) begin
        if (i != s && slot_used[i] && (age_all || slot_rank[i] < rank_cap)) begin
          if (slot_rank[i] != AGE_MAX) slot_rank[i] = slot_rank[i] + 1'b1;
        end
      end
      slot_rank[s] = '0;
    endfunction

    function void note_request(bit [HTYPE_W-1:0] htype, bit [ALEN_W-1:0] alen,
                               bit [MAC_W-1:0] mac, bit [TIME_W-1:0] now);
      int n;
      int slot;
      bit hit;
      bit free_found;
      bit grant;
      int unsigned cap;
      bit [TIME_W-1:0] elapsed;
      n = active_slots();
      cap = (limit_reg == 0) ? DEFAULT_LIMIT : limit_reg;
      slot = 0;
      hit = 1'b0;
      free_found = 1'b0;
      grant = 1'b0;
      if (htype != ETHER_TYPE) begin
        grant = 1'b1;
      end else if (alen == ETHER_ADDR_LEN) begin
        // Lowest matching active slot wins.
        for (int i = 0; i < n && !hit; i++) begin
          if (slot_used[i] && slot_mac[i] == mac) begin
            slot = i;
            hit = 1'b1;
          end
        end
        if (hit) begin
          elapsed = now - slot_window[slot];
          if (elapsed >= WINDOW_MS) begin
            slot_hits[slot] = COUNT_W'(1);
            slot_window[slot] = now;
            grant = 1'b1;
          end else if (int'(slot_hits[slot]) + 1 < cap) begin
            slot_hits[slot] = slot_hits[slot] + 1'b1;
            grant = 1'b1;
          end
          promote(slot, slot_rank[slot], 1'b0, n);
        end else begin
          // New MAC: take the lowest free slot, else evict the oldest one.
          for (int i = 0; i < n && !free_found; i++) begin
            if (!slot_used[i]) begin
              slot = i;
              free_found = 1'b1;
            end
          end
          if (free_found) begin
            promote(slot, '0, 1'b1, n);
          end else begin
            slot = 0;
            for (int i = 1; i < n; i++) begin
              if (slot_rank[i] > slot_rank[slot]) slot = i;
            end
            promote(slot, slot_rank[slot], 1'b0, n);
          end
          slot_used[slot] = 1'b1;
          slot_mac[slot] = mac;
          slot_hits[slot] = COUNT_W'(1);
          slot_window[slot] = now;
          grant = 1'b1;
        end
      end
      verdicts_due.push_back(grant);
    endfunction

    function void check_verdict(bit got);
      bit want;
      checked++;
      if (got) granted++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: verdict %0d (allowed=%0b) arrived with none predicted",
                   checked, got);
      end else begin
        want = verdicts_due.pop_front();
        if (want != got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: verdict %0d expected allowed=%0b, got allowed=%0b",
                     checked, want, got);
        end
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [HTYPE_W-1:0]    hardware_type = '0;
  logic [ALEN_W-1:0]     address_length = '0;
  logic [MAC_W-1:0]      mac_address = '0;
  logic [TIME_W-1:0]     time_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  allowed;

  verdict_scoreboard sb;
  int                accepted_reqs = 0;
  int                quiet_cycles = 0;
  int                settings_used = 0;
  int                holds_started = 0;
  int                hold_left = 0;
  bit [TIME_W-1:0]   clock_ms = 32'hFFFF_F000;
  bit [MAC_W-1:0]    mac_pool [POOL_SIZE];

  per_mac_request_rate_limiter_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .hardware_type  (hardware_type),
    .address_length (address_length),
    .mac_address    (mac_address),
    .time_ms        (time_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .allowed        (allowed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle rates: sender light and receiver heavy, then swapped, then none.
  function int send_idle_pct();
    if (accepted_reqs < 550) return 14;
    if (accepted_reqs < 1100) return 82;
    return 0;
  endfunction

  function int recv_idle_pct();
    if (accepted_reqs < 550) return 82;
    if (accepted_reqs < 1100) return 14;
    return 0;
  endfunction

  // Receiver: random stalls, plus two long hold-offs that back the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_started < 2 &&
                 accepted_reqs >= (holds_started == 0 ? 400 : 1300)) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_started <= holds_started + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Verdict transfers go straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_verdict(allowed);
  end

  // Count cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Offer one request; valid is left high after the transfer so that the
  // next request can follow at once.
  task automatic send_request(bit [HTYPE_W-1:0] htype, bit [ALEN_W-1:0] alen,
                              bit [MAC_W-1:0] mac, bit [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    hardware_type <= htype;
    address_length <= alen;
    mac_address <= mac;
    time_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(htype, alen, mac, now);
    accepted_reqs++;
  endtask

  // Stop offering requests and wait for every predicted verdict.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] lim, logic [CFG_DATA_W-1:0] sz);
    settle();
    cfg_write(REG_MAX_REQUESTS, lim);
    cfg_write(REG_ENTRIES_IN_USE, sz);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed requests from a small MAC pool with a drifting clock.
  task automatic run_random(int count, int pool_n);
    bit [HTYPE_W-1:0] ht;
    bit [ALEN_W-1:0]  al;
    bit [MAC_W-1:0]   mac;
    int               pick;
    int               step;
    for (int k = 0; k < count; k++) begin
      step = $urandom_range(99);
      if (step < 68) clock_ms = clock_ms + $urandom_range(150);
      else if (step < 88) clock_ms = clock_ms + $urandom_range(2600, 1500);
      else if (step >= 96) clock_ms = $urandom();
      pick = $urandom_range(99);
      if (pick < 84) begin
        ht = ETHER_TYPE;
        al = ETHER_ADDR_LEN;
      end else if (pick < 92) begin
        ht = HTYPE_W'($urandom_range(255));
        al = ALEN_W'($urandom_range(16));
      end else begin
        ht = ETHER_TYPE;
        al = ALEN_W'($urandom_range(16));
      end
      if ($urandom_range(99) < 5)
        mac = {16'($urandom()), 32'($urandom())};
      else
        mac = mac_pool[$urandom_range(pool_n - 1)];
      send_request(ht, al, mac, clock_ms);
    end
  endtask

  initial begin
    bit [MAC_W-1:0] mac_a;
    bit [MAC_W-1:0] mac_b;
    sb = new();
    sb.clear();
    for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = {16'($urandom()), 32'($urandom())};
    mac_a = mac_pool[0];
    mac_b = mac_pool[1];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: non-Ethernet passes, bad lengths drop, window edges and wrap.
    send_request(8'd0, ETHER_ADDR_LEN, mac_a, 32'd0);
    send_request(8'hFF, 5'd16, '1, '1);
    send_request(8'd2, 5'd0, '0, 32'd5);
    send_request(ETHER_TYPE, 5'd0, mac_a, 32'd6);
    send_request(ETHER_TYPE, 5'd16, mac_a, 32'd7);
    send_request(ETHER_TYPE, 5'd7, mac_a, 32'd8);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, '0, 32'd0);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, '1, 32'hFFFF_FFFF);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, '1, 32'd1998);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, '1, 32'd1999);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, '0, 32'd1999);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, '0, 32'd2000);

    // Tiny table and tight limit: denial, eviction of the oldest entry.
    settle();
    cfg_write(8'd2, 16'd7);
    cfg_write(8'hFF, 16'hFFFF);
    cfg_valid <= 1'b0;
    set_config(16'd2, 16'd2);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, mac_a, 32'd100);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, mac_a, 32'd101);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, '0, 32'd102);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, mac_b, 32'd103);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, mac_a, 32'd104);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, mac_a, 32'd2200);
    send_request(ETHER_TYPE, ETHER_ADDR_LEN, mac_a, 32'd2201);

    // Random phases over a range of limits and table sizes.
    set_config(16'd3, 16'd4);
    run_random(300, 8);
    set_config(16'd1, 16'd1);
    run_random(120, 3);
    set_config(16'hFFFF, 16'd64);
    run_random(300, POOL_SIZE);
    set_config(16'd0, 16'd0);
    run_random(120, 4);
    set_config(16'd5, 16'd8);
    run_random(200, 12);
    // Shrink with upper bits set in the size write, then grow past the top.
    set_config(16'd4, 16'hFF83);
    run_random(150, 12);
    set_config(16'd6, 16'd127);
    run_random(200, 12);
    set_config(16'd10, 16'd64);
    run_random(250, 20);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d requests under %0d table settings: %0d allowed, %0d denied.",
             accepted_reqs, settings_used + 1, sb.granted, sb.checked - sb.granted);
    $display("Verdicts checked: %0d, mismatches: %0d.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/prl_pkg.sv
hw/rtl/prl_ram.sv
hw/rtl/prl_cfg.sv
hw/rtl/per_mac_request_rate_limiter_top.sv
sim/per_mac_request_rate_limiter_top_tb.sv
